@@ sv/rbpa_pkg.sv @@
// rbpa_pkg: shared widths, codes and transaction types of the region bump page allocator
// no dependencies; used by rbpa_core and region_bump_page_allocator_unit
package rbpa_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int PAGE_BYTES  = 4096;

    localparam int IDX_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int ADDR_W   = 64;
    localparam int TYPE_W   = 8;
    localparam int PAGE_W   = 16;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int REGION_W = 2 * ADDR_W;

    localparam int IN_FIELDS_W  = ADDR_W + ADDR_W + TYPE_W + PAGE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ADDR_W + STAT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SETTLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OUT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BELOW = 2'd3;

    localparam logic [TYPE_W-1:0] TYPE_USABLE = 8'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] region_addr;
        logic [ADDR_W-1:0] region_size;
        logic [TYPE_W-1:0] region_type;
        logic [PAGE_W-1:0] page_count;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

@@ sv/rbpa_ram.sv @@
// rbpa_ram: generic single write port, single read port RAM with registered read
// no dependencies
module rbpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rbpa_core.sv @@
// rbpa_core: sequencer that reads, checks and updates the region table and heap state
// depends on rbpa_pkg and rbpa_ram
module rbpa_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rbpa_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  rbpa_pkg::t_item             i_item,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output rbpa_pkg::t_result           o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    localparam int AW = rbpa_pkg::ADDR_W;
    localparam int CW = rbpa_pkg::CNT_W;

    logic [2:0]                    r_state, n_state;
    logic [AW-1:0]                 r_heap_base;
    logic [CW-1:0]                 r_total, n_total;
    logic [CW-1:0]                 r_cur, n_cur;
    logic [AW-1:0]                 r_offset, n_offset;
    logic [rbpa_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [AW-1:0]                 r_top, n_top;
    logic [AW-1:0]                 r_need, n_need;
    logic [AW-1:0]                 r_nmb, n_nmb;
    logic [AW-1:0]                 r_off_need, n_off_need;
    logic [AW:0]                   r_req_end, n_req_end;
    rbpa_pkg::t_result             r_res, n_res;

    logic                          mem_we;
    logic [rbpa_pkg::REGION_W-1:0] mem_wdata;
    logic [rbpa_pkg::REGION_W-1:0] mem_rdata;
    logic [AW-1:0]                 rd_start;
    logic [AW-1:0]                 rd_len;
    logic [AW:0]                   reg_end;
    logic [AW-1:0]                 need_in;
    logic [CW-1:0]                 cur_next;
    logic                          accept;

    assign need_in = {{(AW - rbpa_pkg::PAGE_W - rbpa_pkg::PAGE_SHIFT){1'b0}},
                      i_item.page_count, {rbpa_pkg::PAGE_SHIFT{1'b0}}};
    assign accept    = i_item_valid && (r_state == S_IDLE);
    assign mem_wdata = {i_item.region_size, i_item.region_addr};
    assign rd_start  = mem_rdata[AW-1:0];
    assign rd_len    = mem_rdata[2*AW-1:AW];
    assign reg_end   = {1'b0, rd_start} + {1'b0, rd_len};
    assign cur_next  = r_cur + CW'(1);

    // table entries are written only by a store in idle and read only in later states
    rbpa_ram #(
        .WIDTH(rbpa_pkg::REGION_W),
        .DEPTH(rbpa_pkg::MAX_REGIONS)
    ) u_region_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_total[rbpa_pkg::IDX_W-1:0]),
        .i_wdata(mem_wdata),
        .i_raddr(r_cur[rbpa_pkg::IDX_W-1:0]),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_cur      = r_cur;
        n_offset   = r_offset;
        n_kind     = r_kind;
        n_top      = r_top;
        n_need     = r_need;
        n_nmb      = r_nmb;
        n_off_need = r_off_need;
        n_req_end  = r_req_end;
        n_res      = r_res;
        mem_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind            = i_item.kind;
                    n_top             = r_heap_base + r_offset;
                    n_need            = need_in;
                    n_nmb             = need_in - r_heap_base;
                    n_off_need        = r_offset + need_in;
                    n_res.alloc_address = '0;
                    n_res.status      = rbpa_pkg::STAT_OK;
                    case (i_item.kind)
                        rbpa_pkg::KIND_STORE: begin
                            if (i_item.region_type == rbpa_pkg::TYPE_USABLE) begin
                                if (r_total < CW'(rbpa_pkg::MAX_REGIONS)) begin
                                    mem_we  = 1'b1;
                                    n_total = r_total + CW'(1);
                                end else begin
                                    n_res.status = rbpa_pkg::STAT_FULL;
                                end
                            end
                            n_state = S_RESP;
                        end
                        rbpa_pkg::KIND_SETTLE: n_state = S_READ;
                        rbpa_pkg::KIND_ALLOC:  n_state = S_READ;
                        default:               n_state = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                n_req_end = {1'b0, r_top} + {1'b0, r_need};
                if (r_cur >= r_total) begin
                    n_res.status = rbpa_pkg::STAT_OUT;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_kind == rbpa_pkg::KIND_SETTLE) begin
                    if ({1'b0, r_top} < reg_end) begin
                        n_res.status = (r_top < rd_start) ? rbpa_pkg::STAT_BELOW
                                                          : rbpa_pkg::STAT_OK;
                        n_state = S_RESP;
                    end else begin
                        n_cur   = cur_next;
                        n_state = S_READ;
                    end
                end else if (reg_end < r_req_end) begin
                    if (cur_next >= r_total) begin
                        n_cur        = r_total;
                        n_res.status = rbpa_pkg::STAT_OUT;
                        n_state      = S_RESP;
                    end else begin
                        n_cur   = cur_next;
                        n_state = S_MOVE;
                    end
                end else begin
                    n_res.alloc_address = r_top;
                    n_offset            = r_off_need;
                    n_state             = S_RESP;
                end
            end
            S_MOVE: n_state = S_LOAD;
            S_LOAD: begin
                n_res.alloc_address = rd_start;
                n_offset            = rd_start + r_nmb;
                n_state             = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_base <= '0;
            r_total     <= '0;
            r_cur       <= '0;
            r_offset    <= '0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cur    <= n_cur;
            r_offset <= n_offset;
            if (i_cfg_we) begin
                r_heap_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_top      <= n_top;
        r_need     <= n_need;
        r_nmb      <= n_nmb;
        r_off_need <= n_off_need;
        r_req_end  <= n_req_end;
        r_res      <= n_res;
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_RESP);
    assign o_res        = r_res;

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_total)
        else $error("current region beyond table");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(rbpa_pkg::MAX_REGIONS))
        else $error("region count beyond capacity");

    a_write_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_total == $past(r_total) + CW'(1)) && (r_state == S_RESP))
        else $error("table write without count update");

    a_resp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) && i_res_ready |=> (r_state == S_IDLE))
        else $error("result handed over but sequencer not idle");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) && !i_res_ready |=> $stable(r_res) && $stable(r_offset))
        else $error("pending result changed");

endmodule

@@ sv/region_bump_page_allocator_unit.sv @@
// region_bump_page_allocator_unit: stream wrapper with output register around rbpa_core
// depends on rbpa_pkg, rbpa_core, rbpa_ram
//
// Input stream: one transaction per request. tuser carries the kind (store region entry,
// settle layout, allocate pages); tdata carries region_addr, region_size, region_type and
// page_count. Output stream: exactly one transaction per request, in request order, with
// alloc_address and status in tdata. The heap base register is written through i_cfg_we/
// i_cfg_wdata; the user must write it only while the block is idle, since the block has no check of its own.
// A store and an unusable kind go from acceptance straight to the result state. An allocate
// reads the current region and checks it: when the request fits it returns the heap top, when
// it does not it moves to the next region, loads that region's start and returns it, and when
// no current region is left it returns out of regions. A settle alternates reads and compares
// along the table until it stops on a region or runs off the table: each table entry costs
// one read of the region RAM and one compare. One request is in the sequencer at a time; the
// next is accepted once the previous result sits in the output register.
// Reset (synchronous, active low) empties the region table and clears the current region,
// the heap offset and the heap base; table contents are not cleared. If the receiver
// stalls, the result waits in the output register, one more result waits in the
// sequencer, and then input is held off.
module region_bump_page_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbpa_pkg::ADDR_W-1:0]      i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // region_addr[63:0], region_size[127:64], region_type[135:128], page_count[151:136]
    input  logic [rbpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [rbpa_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // alloc_address[63:0], status[65:64], zero fill above
    output logic [rbpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = rbpa_pkg::ADDR_W;
    localparam int TW = rbpa_pkg::TYPE_W;
    localparam int PW = rbpa_pkg::PAGE_W;

    rbpa_pkg::t_item   item;
    rbpa_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;
    logic              r_m_valid;
    rbpa_pkg::t_result r_m_res;

    assign item.kind        = s_axis_tuser;
    assign item.region_addr = s_axis_tdata[AW-1:0];
    assign item.region_size = s_axis_tdata[2*AW-1:AW];
    assign item.region_type = s_axis_tdata[2*AW+TW-1:2*AW];
    assign item.page_count  = s_axis_tdata[2*AW+TW+PW-1:2*AW+TW];

    rbpa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item_valid(s_axis_tvalid),
        .o_item_ready(s_axis_tready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(rbpa_pkg::OUT_TDATA_W - rbpa_pkg::OUT_FIELDS_W){1'b0}},
                            r_m_res.status, r_m_res.alloc_address};

endmodule
